FILE: design/efwa_pkg.sv
package efwa_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int DUR_W           = 32;
    localparam int TIME_W          = 48;
    localparam int WIDX_W          = 4;
    localparam int CFG_W           = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } efwa_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic issue;
        logic commit;
    } efwa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic issue_last;
        logic out_free;
    } efwa_sts_t;

endpackage

FILE: design/earliest_free_worker_assigner_core.sv
// A job is taken in the idle state, then the free-time memory is scanned over the
// N active workers, one entry per cycle through its single read port; a new job is taken
// only after the previous result is committed to the output register.
// Reset: aresetn low clears control; afterwards a clearing pass over all MAX_WORKERS
// entries zeroes the free-time memory before the first job is taken.
module earliest_free_worker_assigner_core
    import efwa_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [31:0] job_duration
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata    // [3:0] worker_index, [51:4] start_time, [55:52] zero
);

    efwa_cmd_t         cmd;
    efwa_sts_t         sts;
    logic [WIDX_W-1:0] worker_index;
    logic [TIME_W-1:0] start_time;

    efwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efwa_datapath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .job_duration (s_tdata[DUR_W-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .worker_index (worker_index),
        .start_time   (start_time)
    );

    assign m_tdata = {4'b0000, start_time, worker_index};

endmodule

FILE: design/efwa_ctrl.sv
module efwa_ctrl
    import efwa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  efwa_sts_t sts,
    output efwa_cmd_t cmd
);

    efwa_state_t state_reg;
    efwa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
                cmd = '0;
            end
            ST_UPDATE: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/efwa_datapath.sv
module efwa_datapath
    import efwa_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic [DUR_W-1:0]  job_duration,
    input  efwa_cmd_t         cmd,
    output efwa_sts_t         sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [WIDX_W-1:0] worker_index,
    output logic [TIME_W-1:0] start_time
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WORKERS - 1);
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_WORKERS);

    logic [TIME_W-1:0] mem [MAX_WORKERS];

    logic [CFG_W-1:0]  active_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_time_reg;
    logic              out_valid_reg;
    logic [WIDX_W-1:0] out_idx_reg;
    logic [TIME_W-1:0] out_time_reg;

    logic [CMP_W-1:0]  active_ext;
    logic [CNT_W-1:0]  worker_cnt;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] next_time;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;

    always_comb begin
        active_ext = CMP_W'(active_reg);
        if (active_ext == '0) begin
            worker_cnt = CNT_W'(1);
        end else if (active_ext > MAX_CMP) begin
            worker_cnt = CNT_W'(MAX_WORKERS);
        end else begin
            worker_cnt = CNT_W'(active_ext);
        end
    end

    always_comb begin
        sum = {1'b0, best_time_reg} + (TIME_W + 1)'(dur_reg);
        if (sum[TIME_W]) begin
            next_time = TIME_MAX;
        end else begin
            next_time = sum[TIME_W-1:0];
        end
    end

    assign wr_en   = cmd.clear || cmd.commit;
    assign wr_addr = cmd.clear ? ptr_reg : best_idx_reg;
    assign wr_data = cmd.clear ? '0 : next_time;

    assign sts.clear_last = (ptr_reg == LAST_IDX);
    assign sts.issue_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == worker_cnt);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= CFG_RESET;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                ptr_reg <= '0;
            end else if ((cmd.clear && !sts.clear_last) || (cmd.issue && !sts.issue_last)) begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
            rd_valid_reg <= cmd.issue;
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dur_reg <= job_duration;
        end
        if (cmd.issue) begin
            rd_idx_reg <= ptr_reg;
        end
        if (rd_valid_reg) begin
            if ((rd_idx_reg == '0) || (rd_data_reg < best_time_reg)) begin
                best_time_reg <= rd_data_reg;
                best_idx_reg  <= rd_idx_reg;
            end
        end
        if (cmd.commit) begin
            out_idx_reg  <= WIDX_W'(best_idx_reg);
            out_time_reg <= best_time_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign worker_index = out_idx_reg;
    assign start_time   = out_time_reg;

endmodule

FILE: tb/earliest_free_worker_assigner_core_test.sv
module earliest_free_worker_assigner_core_test
    import efwa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD   = 6;
    localparam int  RESET_CYCLES  = 10;
    localparam int  SETTLE_CYCLES = MAX_WORKERS_DEF + 8;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  PHASE_JOBS    = 150;
    localparam int  NUM_PHASES    = 12;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [WIDX_W-1:0] worker;
        logic [TIME_W-1:0] start;
    } assignment_t;

    class assignment_board;
        logic [TIME_W-1:0] free_time [MAX_WORKERS_DEF];
        logic [CFG_W-1:0]  worker_cfg;
        assignment_t       pending_q [$];
        int                errors;
        int                jobs_taken;
        int                results_seen;

        function new();
            foreach (free_time[i]) free_time[i] = '0;
            worker_cfg   = CFG_RESET;
            errors       = 0;
            jobs_taken   = 0;
            results_seen = 0;
        endfunction

        function void set_workers(logic [CFG_W-1:0] value);
            worker_cfg = value;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_job(logic [DUR_W-1:0] duration);
            int          n;
            int          best;
            logic [TIME_W:0] sum;
            assignment_t a;
            n = int'(worker_cfg);
            if (n < 1) n = 1;
            if (n > MAX_WORKERS_DEF) n = MAX_WORKERS_DEF;
            best = 0;
            for (int j = 1; j < n; j++) begin
                if (free_time[j] < free_time[best]) best = j;
            end
            a.worker = best[WIDX_W-1:0];
            a.start  = free_time[best];
            sum = {1'b0, free_time[best]} + {{(TIME_W-DUR_W+1){1'b0}}, duration};
            free_time[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            pending_q.push_back(a);
            jobs_taken++;
        endfunction

        function void check_result(logic [55:0] data);
            assignment_t want;
            results_seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transaction, data %h", $time, data);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (data[3:0] !== want.worker) begin
                $display("%0t: worker_index mismatch, expected %0d actual %0d",
                         $time, want.worker, data[3:0]);
                errors++;
            end
            if (data[51:4] !== want.start) begin
                $display("%0t: start_time mismatch, expected %h actual %h",
                         $time, want.start, data[51:4]);
                errors++;
            end
            if (data[55:52] !== 4'h0) begin
                $display("%0t: pad bits mismatch, expected 0 actual %h", $time, data[55:52]);
                errors++;
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [55:0]       m_tdata;

    assignment_board   board       = new();
    int                src_idle_pct = 0;
    int                snk_idle_pct = 0;
    logic              hold_req     = 1'b0;
    int                holds_done   = 0;
    int                settings_run = 0;
    longint            cycle_cnt    = 0;

    earliest_free_worker_assigner_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("earliest_free_worker_assigner_core verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (aresetn && s_tvalid && s_tready) board.note_job(s_tdata);
    end

    // receiver: random backpressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                holds_done++;
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_job(input logic [31:0] duration);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= duration;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_workers(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.set_workers(value);
        cfg_wr_en   <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [31:0] random_duration();
        case ($urandom_range(4))
            0:       return $urandom_range(0, 20);
            1:       return {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 3));
            2:       return ($urandom_range(1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_W-1:0] workers, input int jobs,
                             input int src_pct, input int snk_pct,
                             input int hold_at, input int pause_at);
        drain_results();
        write_workers(workers);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < jobs; k++) begin
            if (k == hold_at) hold_req = 1'b1;
            if (k == pause_at) drain_results();
            send_job(random_duration());
        end
    endtask

    logic [31:0]      single_jobs [3]  = '{32'h0, 32'hFFFF_FFFF, 32'h1};
    logic [31:0]      spread_jobs [18] = '{32'h5, 32'h5, 32'h5, 32'h5, 32'h5, 32'h5,
                                           32'h5, 32'h5, 32'h5, 32'h5, 32'h5, 32'h5,
                                           32'h5, 32'h5, 32'h0, 32'hFFFF_FFFF,
                                           32'h8000_0000, 32'h3};
    logic [CFG_W-1:0] phase_cfg [NUM_PHASES] = '{5'd16, 5'd0, 5'd31, 5'd9, 5'd17, 5'd2,
                                                 5'd12, 5'd1, 5'd16, 5'd7, 5'd24, 5'd3};

    initial begin
        int src_pct;
        int snk_pct;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (single_jobs[i]) send_job(single_jobs[i]);
        drain_results();
        write_workers(5'd16);
        foreach (spread_jobs[i]) send_job(spread_jobs[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            src_pct = (p < 4) ? 37 : (p < 8) ? 81 : 0;
            snk_pct = (p < 4) ? 81 : (p < 8) ? 37 : 0;
            run_phase(phase_cfg[p], PHASE_JOBS, src_pct, snk_pct,
                      (p == 5) ? 40 : -1, (p == 9) ? 75 : -1);
        end

        run_phase(5'd16, 50, 0, 0, -1, -1);
        drain_results();

        $display("covered %0d jobs and %0d results across %0d worker settings,",
                 board.jobs_taken, board.results_seen, settings_run);
        $display("with %0d long output hold-offs and a full drain in mid-stream",
                 holds_done);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("earliest_free_worker_assigner_core verification clean");
        end else begin
            if (board.pending() != 0)
                $display("%0t: %0d results never arrived", $time, board.pending());
            $display("earliest_free_worker_assigner_core verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/efwa_pkg.sv
design/efwa_ctrl.sv
design/efwa_datapath.sv
design/earliest_free_worker_assigner_core.sv
tb/earliest_free_worker_assigner_core_test.sv
